FILE: rtl/ackermann_wheel_speed_mixer_assert.svh
// assertion macros for the wheel speed mixer, empty when SYNTH is defined
`ifndef ACKERMANN_WHEEL_SPEED_MIXER_ASSERT_SVH
`define ACKERMANN_WHEEL_SPEED_MIXER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define AWSM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("awsm assertion failed");
// next-cycle implication
`define AWSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("awsm assertion failed");
`else
`define AWSM_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define AWSM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/awsm_pkg.sv
// shared constants, stage payload types and ratio table for the wheel speed mixer
package awsm_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int RATIO_W       = FRACTION_BITS + 1;
    localparam int SCALE_W       = FRACTION_BITS + 1;
    localparam int PROD_W        = 8 + SCALE_W;
    localparam int WHEEL_W       = PROD_W + RATIO_W;
    localparam int ROM_DEPTH     = 128;
    localparam int IDX_W         = $clog2(ROM_DEPTH);

    localparam logic [7:0] CENTER      = 8'd127;
    localparam logic [7:0] SPEED_MAX   = 8'd253;
    localparam logic [7:0] STICK_TOP   = 8'd254;
    localparam logic [7:0] LEFT_OFFSET = 8'd126;

    localparam logic [3:0] DIR_STOP = 4'd0;
    localparam logic [3:0] DIR_FWD  = 4'd7;
    localparam logic [3:0] DIR_BACK = 4'd11;

    localparam logic [7:0] VMAX_RESET   = 8'd192;
    localparam logic [7:0] VMAX_SEL_100 = 8'd192;
    localparam logic [7:0] VMAX_SEL_085 = 8'd193;
    localparam logic [7:0] VMAX_SEL_070 = 8'd194;
    localparam logic [7:0] VMAX_SEL_050 = 8'd195;
    localparam logic [7:0] VMAX_SEL_035 = 8'd196;
    localparam logic [7:0] VMAX_SEL_020 = 8'd197;

    // vmax scales, q1.f rounded half up
    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(64'd1 << FRACTION_BITS);
    localparam logic [SCALE_W-1:0] SCALE_085 =
        SCALE_W'(((64'd85 << FRACTION_BITS) + 64'd50) / 64'd100);
    localparam logic [SCALE_W-1:0] SCALE_070 =
        SCALE_W'(((64'd70 << FRACTION_BITS) + 64'd50) / 64'd100);
    localparam logic [SCALE_W-1:0] SCALE_050 =
        SCALE_W'(((64'd50 << FRACTION_BITS) + 64'd50) / 64'd100);
    localparam logic [SCALE_W-1:0] SCALE_035 =
        SCALE_W'(((64'd35 << FRACTION_BITS) + 64'd50) / 64'd100);
    localparam logic [SCALE_W-1:0] SCALE_020 =
        SCALE_W'(((64'd20 << FRACTION_BITS) + 64'd50) / 64'd100);

    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(64'd1 << FRACTION_BITS);

    // angle series constants in q2.62; WB2_MM and TRACK_MM are in mm
    localparam logic [63:0] PI_Q62   = 64'hC90FDAA22168C234;
    localparam logic [63:0] ONE_Q62  = 64'h4000000000000000;
    localparam logic [63:0] STEP_Q62 = PI_Q62 / 64'd762;
    localparam logic [63:0] WB2_MM   = 64'd3660;
    localparam logic [63:0] TRACK_MM = 64'd1640;

    typedef logic [RATIO_W-1:0] ratio_rom_t [ROM_DEPTH];

    typedef struct packed {
        logic       spin_active;
        logic [3:0] dir_left;
        logic [3:0] dir_right;
        logic [3:0] dir_common;
    } dirs_t;

    typedef struct packed {
        logic [7:0]         raw;
        logic [SCALE_W-1:0] scale;
        logic               inner_left;
        logic               inner_right;
        logic [IDX_W-1:0]   ratio_idx;
        dirs_t              dirs;
    } s1_t;

    typedef struct packed {
        logic [PROD_W-1:0]  prod;
        logic [RATIO_W-1:0] ratio_left;
        logic [RATIO_W-1:0] ratio_right;
        dirs_t              dirs;
    } s2_t;

    typedef struct packed {
        logic [WHEEL_W-1:0] wheel_left;
        logic [WHEEL_W-1:0] wheel_right;
        dirs_t              dirs;
    } s3_t;

    // (a * b) >> 62, truncated to 64 bits
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // inner wheel ratio for deviation d, evaluated at elaboration only
    function automatic logic [RATIO_W-1:0] inner_ratio(input int unsigned d);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        s;
        logic [63:0]        c;
        logic [63:0]        ts;
        logic [63:0]        tc;
        logic [63:0]        num;
        logic [63:0]        den;
        logic [63:0]        r;
        logic [RATIO_W:0]   q;
        x  = STEP_Q62 * 64'(d);
        x2 = mul_q62(x, x);
        s  = x;
        c  = ONE_Q62;
        ts = x;
        tc = ONE_Q62;
        for (int k = 1; k <= 10; k++)
        begin
            ts = mul_q62(ts, x2);
            tc = mul_q62(tc, x2);
            unique case (k)
                1:       begin ts = ts / 64'd6;   tc = tc / 64'd2;   end
                2:       begin ts = ts / 64'd20;  tc = tc / 64'd12;  end
                3:       begin ts = ts / 64'd42;  tc = tc / 64'd30;  end
                4:       begin ts = ts / 64'd72;  tc = tc / 64'd56;  end
                5:       begin ts = ts / 64'd110; tc = tc / 64'd90;  end
                6:       begin ts = ts / 64'd156; tc = tc / 64'd132; end
                7:       begin ts = ts / 64'd210; tc = tc / 64'd182; end
                8:       begin ts = ts / 64'd272; tc = tc / 64'd240; end
                9:       begin ts = ts / 64'd342; tc = tc / 64'd306; end
                default: begin ts = ts / 64'd420; tc = tc / 64'd380; end
            endcase
            if ((k & 1) != 0)
            begin
                s = s - ts;
                c = c - tc;
            end
            else
            begin
                s = s + ts;
                c = c + tc;
            end
        end
        c   = c >> 22;
        s   = s >> 22;
        num = WB2_MM * c - TRACK_MM * s;
        den = WB2_MM * c + TRACK_MM * s;
        r   = num;
        q   = '0;
        for (int k = 0; k < FRACTION_BITS + 1; k++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r    = r - den;
                q[0] = 1'b1;
            end
        end
        q = q + (RATIO_W + 1)'(1);
        return RATIO_W'(q >> 1);
    endfunction

    // entry i holds the ratio for deviation i + 1
    function automatic ratio_rom_t build_ratio_rom();
        ratio_rom_t rom;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            rom[i] = inner_ratio(i + 1);
        end
        return rom;
    endfunction

    localparam ratio_rom_t RATIO_ROM = build_ratio_rom();

endpackage

FILE: rtl/awsm_decode.sv
// stage 1: stick mapping, mode decode and vmax scale selection
module awsm_decode
    import awsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] accel_stick,
    input  logic [7:0] steer_stick,
    input  logic       forward,
    input  logic       spin,
    input  logic [7:0] vmax_select,
    output logic       out_valid,
    input  logic       out_ready,
    output s1_t        out_data
);

    logic valid_reg;
    s1_t  data_reg;
    s1_t  data_next;

    // 253 = 2*127 - 1, so floor(x*253/127) = 2x - 1 for x in 1..126; used for forward, x = j - 127
    function automatic logic [7:0] map_speed(input logic [7:0] j, input logic fwd);
        logic [8:0] dbl;
        dbl = {j, 1'b0};
        if (fwd)
        begin
            priority if (j <= CENTER)    return 8'd0;
            else if (j >= STICK_TOP)     return SPEED_MAX;
            else                         return 8'(dbl - 9'd255);
        end
        else
        begin
            priority if (j == 8'd0)      return SPEED_MAX;
            else if (j >= CENTER)        return 8'd0;
            else                         return 8'(9'd254 - dbl);
        end
    endfunction

    function automatic logic [SCALE_W-1:0] vmax_scale(input logic [7:0] sel);
        logic [SCALE_W-1:0] sc;
        unique case (sel)
            VMAX_SEL_100: sc = SCALE_ONE;
            VMAX_SEL_085: sc = SCALE_085;
            VMAX_SEL_070: sc = SCALE_070;
            VMAX_SEL_050: sc = SCALE_050;
            VMAX_SEL_035: sc = SCALE_035;
            VMAX_SEL_020: sc = SCALE_020;
            default:      sc = SCALE_ONE;
        endcase
        return sc;
    endfunction

    always_comb
    begin
        data_next = '0;
        if (spin)
        begin
            // turn in place: unit ratio and unit scale pass the speed through
            data_next.scale            = SCALE_ONE;
            data_next.dirs.spin_active = 1'b1;
            data_next.dirs.dir_common  = DIR_STOP;
            priority if (steer_stick > CENTER)
            begin
                data_next.raw            = map_speed(steer_stick, 1'b1);
                data_next.dirs.dir_left  = DIR_FWD;
                data_next.dirs.dir_right = DIR_BACK;
            end
            else if (steer_stick < CENTER)
            begin
                data_next.raw            = map_speed(steer_stick, 1'b0);
                data_next.dirs.dir_left  = DIR_BACK;
                data_next.dirs.dir_right = DIR_FWD;
            end
            else
            begin
                data_next.raw            = 8'd0;
                data_next.dirs.dir_left  = DIR_STOP;
                data_next.dirs.dir_right = DIR_STOP;
            end
        end
        else
        begin
            data_next.raw              = map_speed(accel_stick, forward);
            data_next.scale            = vmax_scale(vmax_select);
            data_next.inner_left       = (steer_stick < CENTER);
            data_next.inner_right      = (steer_stick > CENTER);
            data_next.ratio_idx        = steer_stick[7] ? steer_stick[IDX_W-1:0]
                                                        : IDX_W'(LEFT_OFFSET - steer_stick);
            data_next.dirs.spin_active = 1'b0;
            data_next.dirs.dir_left    = DIR_STOP;
            data_next.dirs.dir_right   = DIR_STOP;
            data_next.dirs.dir_common  = forward ? DIR_FWD : DIR_BACK;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/awsm_lookup.sv
// stage 2: inner wheel ratio table read and speed times vmax scale
module awsm_lookup
    import awsm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  s1_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output s2_t  out_data
);

    logic               valid_reg;
    s2_t                data_reg;
    s2_t                data_next;
    logic [RATIO_W-1:0] rom_ratio;

    assign rom_ratio = RATIO_ROM[in_data.ratio_idx];

    always_comb
    begin
        data_next             = '0;
        data_next.prod        = PROD_W'(in_data.raw) * PROD_W'(in_data.scale);
        data_next.ratio_left  = in_data.inner_left  ? rom_ratio : RATIO_ONE;
        data_next.ratio_right = in_data.inner_right ? rom_ratio : RATIO_ONE;
        data_next.dirs        = in_data.dirs;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/awsm_wheel.sv
// stage 3: per-wheel multiply by the steering ratio
module awsm_wheel
    import awsm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  s2_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output s3_t  out_data
);

    logic valid_reg;
    s3_t  data_reg;
    s3_t  data_next;

    always_comb
    begin
        data_next.wheel_left  = WHEEL_W'(in_data.prod) * WHEEL_W'(in_data.ratio_left);
        data_next.wheel_right = WHEEL_W'(in_data.prod) * WHEEL_W'(in_data.ratio_right);
        data_next.dirs        = in_data.dirs;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/ackermann_wheel_speed_mixer.sv
// top level of the ackermann wheel speed mixer: stage chain, vmax register, output stage
// an accepted input beat passes the decode, lookup, wheel and output registers in order
// throughput: one beat per cycle; the four registered stages each hold one beat
// and stall only while the output is held by out_ready low; an empty stage still takes a beat
// reset: rst_n clears every stage valid bit and loads vmax_select with 192 (scale 1.0)
// no clearing pass; the ratio table is constant logic
`include "ackermann_wheel_speed_mixer_assert.svh"
module ackermann_wheel_speed_mixer
    import awsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] accel_stick,
    input  logic [7:0] steer_stick,
    input  logic       forward,
    input  logic       spin,
    // vmax_select register write
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    // output channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] speed_left,
    output logic [7:0] speed_right,
    output logic       spin_active,
    output logic [3:0] dir_left,
    output logic [3:0] dir_right,
    output logic [3:0] dir_common
);

    // speed limit selector; the user writes it only while the pipeline is empty (unchecked)
    logic [7:0] vmax_select_reg;

    // stage handshakes
    logic s1_valid;
    logic s1_ready;
    s1_t  s1_data;
    logic s2_valid;
    logic s2_ready;
    s2_t  s2_data;
    logic s3_valid;
    logic s3_ready;
    s3_t  s3_data;

    // output stage
    logic       out_valid_reg;
    logic [7:0] speed_left_reg;
    logic [7:0] speed_right_reg;
    dirs_t      dirs_reg;
    logic [7:0] speed_left_next;
    logic [7:0] speed_right_next;

    // result shape checks for the assertions below
    logic spin_result_ok;
    logic drive_result_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vmax_select_reg <= VMAX_RESET;
        end
        else if (cfg_wr_en)
        begin
            vmax_select_reg <= cfg_wr_data;
        end
    end

    // stage 1: decode the sticks into raw speed, ratio index and scale
    awsm_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .accel_stick (accel_stick),
        .steer_stick (steer_stick),
        .forward     (forward),
        .spin        (spin),
        .vmax_select (vmax_select_reg),
        .out_valid   (s1_valid),
        .out_ready   (s1_ready),
        .out_data    (s1_data)
    );

    // stage 2: table read for the inner wheel, raw speed times vmax scale
    awsm_lookup u_lookup (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // stage 3: one multiplier per wheel applies the steering ratio
    awsm_wheel u_wheel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    // stage 4: single truncation of the q.2f product back to a speed byte;
    // the product never exceeds 253 so the low byte of the integer part is exact
    assign speed_left_next  = s3_data.wheel_left[2*FRACTION_BITS +: 8];
    assign speed_right_next = s3_data.wheel_right[2*FRACTION_BITS +: 8];

    // output register frees itself when the beat is taken or when it is empty
    assign s3_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            out_valid_reg <= s3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s3_valid)
        begin
            speed_left_reg  <= speed_left_next;
            speed_right_reg <= speed_right_next;
            dirs_reg        <= s3_data.dirs;
        end
    end

    assign out_valid   = out_valid_reg;
    assign speed_left  = speed_left_reg;
    assign speed_right = speed_right_reg;
    assign spin_active = dirs_reg.spin_active;
    assign dir_left    = dirs_reg.dir_left;
    assign dir_right   = dirs_reg.dir_right;
    assign dir_common  = dirs_reg.dir_common;

    // spin results drive both wheels equally and no common direction
    assign spin_result_ok  = (speed_left == speed_right) && (dir_common == DIR_STOP);
    // ackermann results carry only the common direction and bounded speeds
    assign drive_result_ok = (dir_left == DIR_STOP) && (dir_right == DIR_STOP)
                             && (speed_left <= SPEED_MAX) && (speed_right <= SPEED_MAX)
                             && ((dir_common == DIR_FWD) || (dir_common == DIR_BACK));

    // an empty output stage lets the whole ready chain through to the input
    `AWSM_ASSERT_IMPLY(a_ready_when_drained, clk, rst_n, !out_valid_reg, in_ready)
    // an accepted beat always occupies the first stage next cycle
    `AWSM_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_valid && in_ready, s1_valid)
    `AWSM_ASSERT_IMPLY(a_spin_result, clk, rst_n, out_valid && spin_active, spin_result_ok)
    `AWSM_ASSERT_IMPLY(a_drive_result, clk, rst_n, out_valid && !spin_active, drive_result_ok)

endmodule
